// ===== hdl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg: shared types, codes and helpers
// Request/result payloads, status and request codes, and the decoded
// operation that travels from the front end to the count engine.
// ----------------------------------------------------------------------------
package hbc_pkg;

  localparam int MAX_BINS   = 16;
  localparam int EDGE_SLOTS = MAX_BINS + 1;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = 32;
  localparam int SLOT_W     = 5;
  localparam int BIN_W      = 4;
  localparam int STAT_W     = 3;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_BINNED = 3'd0;
  localparam logic [STAT_W-1:0] ST_BELOW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_ABOVE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_GAP    = 3'd3;
  localparam logic [STAT_W-1:0] ST_REJECT = 3'd4;
  localparam logic [STAT_W-1:0] ST_DONE   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_LOWER = 2'd0;
  localparam logic [1:0] CFG_UPPER = 2'd1;
  localparam logic [1:0] CFG_EDGES = 2'd2;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [VALUE_BITS-1:0] value;
    logic [SLOT_W-1:0]            slot;
  } hbc_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BIN_W-1:0]  bin_number;
    logic [CNT_W-1:0]  bin_total;
    logic [CNT_W-1:0]  below_total;
    logic [CNT_W-1:0]  above_total;
    logic [CNT_W-1:0]  population;
  } hbc_out_t;

  // classified request: status already decided for samples and edge writes
  typedef struct packed {
    logic [1:0]        req;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] idx;     // bin hit for a sample, slot for a read
  } hbc_op_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// ===== hdl/histogram_binning_with_cut_table.sv =====
// ----------------------------------------------------------------------------
// histogram_binning_with_cut_table: histogram engine with programmable edges
// Classifies Q16.16 samples against an edge table and keeps saturating
// bin, below, above and population counts.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_push/in_full as a queue: a request is taken at a
//   clock edge with in_push high and in_full low. Kinds: add sample, write
//   edge, read bin count, clear counts. Each request gives one result.
//   Results leave on out_empty/out_pop: the oldest result sits on out_data
//   while out_empty is low and is taken at an edge with out_pop high.
//   Config registers (lower bound, upper bound, edges in use) are written
//   through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
//   high. Write config only while no request is in flight.
//   A taken request is written into the queue, then moves into the result
//   register and shows on out_data; a stall can hold it in the queue.
//   Throughput: one request per cycle while in_full is low, set by the
//   combinational compare of a sample against all edges in the front end
//   and the count update the back end makes as it takes each operation.
//   A stalled receiver holds the result register; the four-entry queue
//   between front and back then fills and in_full rises.
//   Reset clears counts and config (lower 0, upper 65536, edges in use 2);
//   edges are undefined until written.
// ----------------------------------------------------------------------------
module histogram_binning_with_cut_table import hbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  hbc_in_t               in_data,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output hbc_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data
);

  // decoded request stream between front end and count engine
  logic    op_push, op_full, op_pop, op_empty;
  hbc_op_t op_wr, op_rd;

  hbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op_push   (op_push),
    .op_data   (op_wr),
    .op_full   (op_full)
  );

  hbc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .wr_data (op_wr),
    .full    (op_full),
    .pop     (op_pop),
    .rd_data (op_rd),
    .empty   (op_empty)
  );

  hbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_data   (op_rd),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  // a binned sample always leaves a nonzero bin count
  a_binned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status == ST_BINNED) |-> (out_data.bin_total != '0))
    else $error("binned result with zero bin count");

  // every below or above sample counts toward the population
  a_below_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_data.status == ST_BELOW || out_data.status == ST_ABOVE))
      |-> (out_data.population != '0))
    else $error("classified sample missing from population");

  // the engine only drains the queue when the result register is free or being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && !out_empty) |-> out_pop)
    else $error("result register overwritten while held");

endmodule

// ===== hdl/hbc_front.sv =====
// ----------------------------------------------------------------------------
// hbc_front: request intake and classification
// Holds the configuration and the edge table, compares a sample against
// all edges at once and queues the decoded operation.
// ----------------------------------------------------------------------------
module hbc_front import hbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  hbc_in_t               in_data,
  output logic                  in_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data,
  output logic                  op_push,
  output hbc_op_t               op_data,
  input  logic                  op_full
);

  logic signed [VALUE_BITS-1:0] lower_r, upper_r;
  logic [SLOT_W-1:0]            edges_r;
  logic signed [VALUE_BITS-1:0] edge_r [EDGE_SLOTS];

  logic                         accept;
  logic signed [VALUE_BITS-1:0] x;
  logic [SLOT_W-1:0]            ne, nb;
  logic [MAX_BINS-1:0]          hit;
  logic                         any_hit;
  logic [BIN_W-1:0]             hit_idx;
  logic                         reject;

  assign cfg_ready = 1'b1;
  assign in_full   = op_full;
  assign accept    = in_push && !op_full;
  assign op_push   = accept;
  assign x         = in_data.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= VALUE_BITS'(65536);
      edges_r <= SLOT_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOWER: lower_r <= cfg_data;
        CFG_UPPER: upper_r <= cfg_data;
        CFG_EDGES: edges_r <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp edge count, derive bins in use
  always_comb begin
    ne = (edges_r > SLOT_W'(EDGE_SLOTS)) ? SLOT_W'(EDGE_SLOTS) : edges_r;
    nb = (ne < SLOT_W'(2)) ? '0 : ne - 1'b1;
  end

  always_comb begin
    for (int i = 0; i < MAX_BINS; i++) begin
      hit[i] = (SLOT_W'(i) < nb) && (edge_r[i] <= x) && (x < edge_r[i+1]);
    end
  end

  // lowest numbered bin wins
  always_comb begin
    any_hit = |hit;
    hit_idx = '0;
    for (int i = MAX_BINS - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = BIN_W'(i);
    end
  end

  assign reject = (in_data.slot >= SLOT_W'(EDGE_SLOTS)) || (x < lower_r) || (x > upper_r);

  always_comb begin
    op_data.req    = in_data.req_type;
    op_data.status = ST_DONE;
    op_data.idx    = in_data.slot;
    case (in_data.req_type)
      REQ_ADD: begin
        op_data.idx = {1'b0, hit_idx};
        if (x < lower_r)       op_data.status = ST_BELOW;
        else if (any_hit)      op_data.status = ST_BINNED;
        else if (x >= upper_r) op_data.status = ST_ABOVE;
        else                   op_data.status = ST_GAP;
      end
      REQ_EDGE: op_data.status = reject ? ST_REJECT : ST_DONE;
      default:  op_data.status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type == REQ_EDGE && !reject) begin
      edge_r[in_data.slot] <= x;
    end
  end

endmodule

// ===== hdl/hbc_fifo.sv =====
// ----------------------------------------------------------------------------
// hbc_fifo: operation queue
// Small register queue between the front end and the count engine.
// ----------------------------------------------------------------------------
module hbc_fifo import hbc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  hbc_op_t wr_data,
  output logic    full,
  input  logic    pop,
  output hbc_op_t rd_data,
  output logic    empty
);

  hbc_op_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== hdl/hbc_back.sv =====
// ----------------------------------------------------------------------------
// hbc_back: count engine
// Applies queued operations to the counters and holds the result register.
// ----------------------------------------------------------------------------
module hbc_back import hbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  hbc_op_t  op_data,
  input  logic     op_empty,
  output logic     op_pop,
  input  logic     out_pop,
  output logic     out_empty,
  output hbc_out_t out_data
);

  logic [CNT_W-1:0] bin_r [MAX_BINS];
  logic [CNT_W-1:0] below_r, above_r, pop_r;
  logic [CNT_W-1:0] below_nxt, above_nxt, pop_nxt;
  logic             valid_r;
  hbc_out_t         res_r, res_nxt;

  logic [BIN_W-1:0] bidx;
  logic [CNT_W-1:0] rd_cnt, bin_new;
  logic             bin_we, bin_clr;

  assign op_pop    = !op_empty && (!valid_r || out_pop);
  assign out_empty = !valid_r;
  assign out_data  = res_r;
  assign bidx      = op_data.idx[BIN_W-1:0];
  assign rd_cnt    = bin_r[bidx];
  assign bin_new   = sat_inc(rd_cnt);

  always_comb begin
    below_nxt = below_r;
    above_nxt = above_r;
    pop_nxt   = pop_r;
    bin_we    = 1'b0;
    bin_clr   = 1'b0;
    res_nxt.status     = op_data.status;
    res_nxt.bin_number = '0;
    res_nxt.bin_total  = '0;
    case (op_data.req)
      REQ_ADD: begin
        pop_nxt = sat_inc(pop_r);
        case (op_data.status)
          ST_BELOW: below_nxt = sat_inc(below_r);
          ST_ABOVE: above_nxt = sat_inc(above_r);
          ST_BINNED: begin
            bin_we             = 1'b1;
            res_nxt.bin_number = bidx;
            res_nxt.bin_total  = bin_new;
          end
          default: ;
        endcase
      end
      REQ_READ: begin
        if (op_data.idx < SLOT_W'(MAX_BINS)) begin
          res_nxt.bin_number = bidx;
          res_nxt.bin_total  = rd_cnt;
        end
      end
      REQ_CLEAR: begin
        bin_clr   = 1'b1;
        below_nxt = '0;
        above_nxt = '0;
        pop_nxt   = '0;
      end
      default: ;
    endcase
    res_nxt.below_total = below_nxt;
    res_nxt.above_total = above_nxt;
    res_nxt.population  = pop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      below_r <= '0;
      above_r <= '0;
      pop_r   <= '0;
      for (int i = 0; i < MAX_BINS; i++) bin_r[i] <= '0;
    end else begin
      if (op_pop) begin
        valid_r <= 1'b1;
        below_r <= below_nxt;
        above_r <= above_nxt;
        pop_r   <= pop_nxt;
        if (bin_clr) begin
          for (int i = 0; i < MAX_BINS; i++) bin_r[i] <= '0;
        end else if (bin_we) begin
          bin_r[bidx] <= bin_new;
        end
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) res_r <= res_nxt;
  end

endmodule
